// ----- hdl/grc_pkg.sv -----
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types for the graph reachability closure unit.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int unsigned VERTEX_W = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_LINK,
    ST_EDGE_TAIL,
    ST_HEAD_RD,
    ST_HEAD_CHK,
    ST_EDGE_RD,
    ST_EDGE_CHK,
    ST_NEXT,
    ST_POP_CHK,
    ST_SELF,
    ST_FINISH
  } state_t;

  typedef enum logic {
    KIND_EDGE   = 1'b0,
    KIND_SEARCH = 1'b1
  } kind_t;

endpackage

// ----- hdl/graph_reachability_closure_unit.sv -----
// ----------------------------------------------------------------------------
// graph_reachability_closure_unit
// Successor-list edge store with depth-first reachability search.
// ----------------------------------------------------------------------------
// An edge request passes through the EDGE_LINK and EDGE_TAIL states. A search
// request does one edge memory read and one check per successor-list entry
// visited, and a pop, stack read, head read and head check per vertex popped
// from the walk stack, plus setup and finish; it also waits while the result
// side stalls.
// Results leave through a one-entry output register; the newest reached
// vertex is held back one step so that the final result carries last.
module graph_reachability_closure_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [5:0] from_vertex,
  input  logic [5:0] to_vertex,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] source_vertex,
  output logic [5:0] reached_vertex,
  output logic       found,
  output logic       last,
  output logic       edges_dropped
);

  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int DW  = $clog2(MAX_VERTICES + 1);
  localparam logic [EW-1:0] END_MARK = EW'(MAX_EDGES);

  logic [grc_pkg::VERTEX_W-1:0] target_mem [MAX_EDGES];
  logic [EW-1:0]                link_mem   [MAX_EDGES];
  logic [AW-1:0]                head_mem   [MAX_VERTICES];
  logic [AW-1:0]                tail_mem   [MAX_VERTICES];
  logic [grc_pkg::VERTEX_W-1:0] stack_mem  [MAX_VERTICES];

  grc_pkg::state_t state, state_next;

  logic                         include_self;
  logic                         overflow_flag;
  logic [EW-1:0]                edge_count;
  logic [MAX_VERTICES-1:0]      head_valid;
  logic [MAX_VERTICES-1:0]      visited;
  logic [DW-1:0]                stack_depth;
  logic [grc_pkg::VERTEX_W-1:0] ed_from, ed_to;
  logic [grc_pkg::VERTEX_W-1:0] src, v;
  logic [AW-1:0]                e;
  logic                         pend_valid;
  logic [grc_pkg::VERTEX_W-1:0] pend_reached;

  logic [grc_pkg::VERTEX_W-1:0] target_rd;
  logic [EW-1:0]                link_rd;
  logic [AW-1:0]                head_rd, tail_rd;
  logic [grc_pkg::VERTEX_W-1:0] stack_rd;

  logic in_accept, from_ok, to_ok, store_full;
  logic out_free, can_emit, is_new, want_self;
  logic emit_new, fin_load, load_out;
  logic [grc_pkg::VERTEX_W-1:0] emit_vertex;

  assign in_stall   = (state != grc_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign from_ok    = ({26'd0, from_vertex} < 32'(MAX_VERTICES));
  assign to_ok      = ({26'd0, to_vertex} < 32'(MAX_VERTICES));
  assign store_full = (edge_count == END_MARK);
  assign out_free   = !out_valid || !out_stall;
  assign can_emit   = !pend_valid || out_free;
  assign is_new     = !visited[target_rd[VAW-1:0]];
  assign want_self  = include_self && !visited[src[VAW-1:0]];

  always_comb begin
    state_next = state;
    case (state)
      grc_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (kind == grc_pkg::KIND_SEARCH) begin
            state_next = from_ok ? grc_pkg::ST_HEAD_RD : grc_pkg::ST_FINISH;
          end else if (from_ok && to_ok && !store_full) begin
            state_next = grc_pkg::ST_EDGE_LINK;
          end
        end
      end
      grc_pkg::ST_EDGE_LINK: state_next = grc_pkg::ST_EDGE_TAIL;
      grc_pkg::ST_EDGE_TAIL: state_next = grc_pkg::ST_IDLE;
      grc_pkg::ST_HEAD_RD:   state_next = grc_pkg::ST_HEAD_CHK;
      grc_pkg::ST_HEAD_CHK: begin
        state_next = head_valid[v[VAW-1:0]] ? grc_pkg::ST_EDGE_RD : grc_pkg::ST_NEXT;
      end
      grc_pkg::ST_EDGE_RD:   state_next = grc_pkg::ST_EDGE_CHK;
      grc_pkg::ST_EDGE_CHK: begin
        if (!(is_new && !can_emit)) begin
          state_next = (link_rd == END_MARK) ? grc_pkg::ST_NEXT : grc_pkg::ST_EDGE_RD;
        end
      end
      grc_pkg::ST_NEXT: begin
        state_next = (stack_depth != '0) ? grc_pkg::ST_POP_CHK : grc_pkg::ST_SELF;
      end
      grc_pkg::ST_POP_CHK:   state_next = grc_pkg::ST_HEAD_RD;
      grc_pkg::ST_SELF: begin
        if (!(want_self && !can_emit)) state_next = grc_pkg::ST_FINISH;
      end
      grc_pkg::ST_FINISH: begin
        if (out_free) state_next = grc_pkg::ST_IDLE;
      end
      default: state_next = grc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    emit_new    = 1'b0;
    emit_vertex = target_rd;
    fin_load    = 1'b0;
    case (state)
      grc_pkg::ST_EDGE_CHK: emit_new = is_new && can_emit;
      grc_pkg::ST_SELF: begin
        emit_new    = want_self && can_emit;
        emit_vertex = src;
      end
      grc_pkg::ST_FINISH: fin_load = out_free;
      default: ;
    endcase
    load_out = (emit_new && pend_valid) || fin_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= grc_pkg::ST_IDLE;
      include_self  <= 1'b0;
      overflow_flag <= 1'b0;
      edge_count    <= '0;
      head_valid    <= '0;
      visited       <= '0;
      stack_depth   <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) include_self <= cfg_wdata;
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        grc_pkg::ST_IDLE: begin
          if (in_accept) begin
            if (kind == grc_pkg::KIND_SEARCH) begin
              visited     <= '0;
              stack_depth <= '0;
              pend_valid  <= 1'b0;
            end else if (from_ok && to_ok && store_full) begin
              overflow_flag <= 1'b1;
            end
          end
        end
        grc_pkg::ST_EDGE_TAIL: begin
          head_valid[ed_from[VAW-1:0]] <= 1'b1;
          edge_count <= edge_count + EW'(1);
        end
        grc_pkg::ST_EDGE_CHK: begin
          if (emit_new) begin
            visited[target_rd[VAW-1:0]] <= 1'b1;
            stack_depth <= stack_depth + DW'(1);
          end
        end
        grc_pkg::ST_NEXT: begin
          if (stack_depth != '0) stack_depth <= stack_depth - DW'(1);
        end
        grc_pkg::ST_FINISH: begin
          if (out_free) pend_valid <= 1'b0;
        end
        default: ;
      endcase
      if (emit_new) pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ed_from <= from_vertex;
      ed_to   <= to_vertex;
      src     <= from_vertex;
      v       <= from_vertex;
    end
    if (state == grc_pkg::ST_HEAD_CHK) e <= head_rd;
    if (state == grc_pkg::ST_EDGE_CHK && state_next == grc_pkg::ST_EDGE_RD) begin
      e <= link_rd[AW-1:0];
    end
    if (state == grc_pkg::ST_POP_CHK) v <= stack_rd;
    if (emit_new) pend_reached <= emit_vertex;
    if (load_out) begin
      source_vertex  <= src;
      edges_dropped  <= overflow_flag;
      found          <= fin_load ? pend_valid : 1'b1;
      reached_vertex <= (fin_load && !pend_valid) ? '0 : pend_reached;
      last           <= fin_load;
    end
  end

  always_ff @(posedge clk) begin
    if (state == grc_pkg::ST_EDGE_LINK) target_mem[edge_count[AW-1:0]] <= ed_to;
    if (state == grc_pkg::ST_EDGE_RD) target_rd <= target_mem[e];
  end

  always_ff @(posedge clk) begin
    if (state == grc_pkg::ST_EDGE_LINK) begin
      link_mem[edge_count[AW-1:0]] <= END_MARK;
    end else if (state == grc_pkg::ST_EDGE_TAIL && head_valid[ed_from[VAW-1:0]]) begin
      link_mem[tail_rd] <= edge_count;
    end
    if (state == grc_pkg::ST_EDGE_RD) link_rd <= link_mem[e];
  end

  always_ff @(posedge clk) begin
    if (state == grc_pkg::ST_EDGE_TAIL && !head_valid[ed_from[VAW-1:0]]) begin
      head_mem[ed_from[VAW-1:0]] <= edge_count[AW-1:0];
    end
    if (state == grc_pkg::ST_HEAD_RD) head_rd <= head_mem[v[VAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == grc_pkg::ST_EDGE_TAIL) tail_mem[ed_from[VAW-1:0]] <= edge_count[AW-1:0];
    if (state == grc_pkg::ST_EDGE_LINK) tail_rd <= tail_mem[ed_from[VAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == grc_pkg::ST_EDGE_CHK && emit_new) begin
      stack_mem[stack_depth[VAW-1:0]] <= target_rd;
    end
    if (state == grc_pkg::ST_NEXT && stack_depth != '0) begin
      stack_rd <= stack_mem[VAW'(stack_depth - DW'(1))];
    end
  end

  assert property (@(posedge clk) disable iff (rst) load_out |-> out_free)
    else $error("result register overwritten before it was taken");
  assert property (@(posedge clk) disable iff (rst) stack_depth <= DW'(MAX_VERTICES))
    else $error("walk stack overflow");
  assert property (@(posedge clk) disable iff (rst) edge_count <= END_MARK)
    else $error("edge count beyond store size");
  assert property (@(posedge clk) disable iff (rst) overflow_flag |=> overflow_flag)
    else $error("sticky overflow flag cleared");

endmodule

// ----- verif/tb_graph_reachability_closure_unit.sv -----
// ----------------------------------------------------------------------------
// tb_graph_reachability_closure_unit
// Drives edge and search requests with random idling and stalls, predicts the
// depth-first discovery order of every search and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_graph_reachability_closure_unit;

  localparam int NV = 64;
  localparam int NE = 256;

  typedef struct packed {
    logic [5:0] src;
    logic [5:0] reached;
    logic       found;
    logic       last;
    logic       dropped;
  } pair_t;

  class reach_scoreboard;
    logic [5:0] targets [NE];
    int         links [NE];
    int         heads [NV];
    int         tails [NV];
    int         n_edges;
    logic       overflow;
    logic       self_en;
    pair_t      pending [$];
    int         errors;

    function void clear();
      for (int i = 0; i < NV; i++) heads[i] = NE;
      n_edges = 0;
      overflow = 0;
      self_en = 0;
      errors = 0;
    endfunction

    function void add_pair(logic [5:0] s, logic [5:0] r, logic f);
      pair_t p;
      p.src = s;
      p.reached = r;
      p.found = f;
      p.last = 0;
      p.dropped = overflow;
      pending.insert(pending.size(), p);
    endfunction

    function void scan(int v, logic [5:0] s, ref logic [63:0] seen, ref int stk[NV],
                       ref int sp, ref int cnt);
      int e;
      e = heads[v];
      while (e < NE) begin
        if (!seen[targets[e]]) begin
          seen[targets[e]] = 1;
          stk[sp] = targets[e];
          sp++;
          add_pair(s, targets[e], 1);
          cnt++;
        end
        e = links[e];
      end
    endfunction

    function void note_request(grc_pkg::kind_t k, logic [5:0] fv, logic [5:0] tv);
      logic [63:0] seen;
      int stk[NV];
      int sp;
      int cnt;
      if (k == grc_pkg::KIND_EDGE) begin
        if (n_edges >= NE) begin
          overflow = 1;
          return;
        end
        targets[n_edges] = tv;
        links[n_edges] = NE;
        if (heads[fv] >= NE) heads[fv] = n_edges;
        else links[tails[fv]] = n_edges;
        tails[fv] = n_edges;
        n_edges++;
        return;
      end
      seen = '0;
      cnt = 0;
      sp = 0;
      scan(fv, fv, seen, stk, sp, cnt);
      while (sp > 0) begin
        sp--;
        scan(stk[sp], fv, seen, stk, sp, cnt);
      end
      if (self_en && !seen[fv]) begin
        add_pair(fv, fv, 1);
        cnt++;
      end
      if (cnt == 0) add_pair(fv, 6'd0, 0);
      pending[pending.size() - 1].last = 1;
    endfunction

    function void check_result(pair_t act);
      pair_t exp_p;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", act);
        return;
      end
      exp_p = pending.pop_front();
      if (exp_p != act) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", exp_p, act);
      end
    endfunction
  endclass

  logic clk, rst, cfg_we, cfg_wdata, in_valid, in_stall, kind;
  logic [5:0] from_vertex, to_vertex, source_vertex, reached_vertex;
  logic out_valid, out_stall, found, last, edges_dropped;
  reach_scoreboard sb;
  int idle_pct;
  bit sending_done;

  graph_reachability_closure_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .from_vertex(from_vertex), .to_vertex(to_vertex),
    .out_valid(out_valid), .out_stall(out_stall),
    .source_vertex(source_vertex), .reached_vertex(reached_vertex),
    .found(found), .last(last), .edges_dropped(edges_dropped)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_request(grc_pkg::kind_t k, logic [5:0] fv, logic [5:0] tv);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    kind <= k;
    from_vertex <= fv;
    to_vertex <= tv;
    do @(posedge clk); while (in_stall);
    sb.note_request(k, fv, tv);
    @(negedge clk);
  endtask

  task automatic write_include_self(logic v);
    in_valid <= 0;
    while (sb.pending.size() > 0) @(negedge clk);
    repeat (600) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.self_en = v;
  endtask

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check_result(pair_t'{source_vertex, reached_vertex, found, last, edges_dropped});

  always @(negedge clk)
    out_stall <= (!sending_done || 1) && ($urandom_range(99) < idle_pct);

  initial begin
    sb = new();
    sb.clear();
    rst = 1; cfg_we = 0; cfg_wdata = 0; in_valid = 0; kind = 0;
    from_vertex = 0; to_vertex = 0; out_stall = 0; idle_pct = 34;
    sending_done = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // empty graph, both extremes of vertex ids, then a small fixed graph
    send_request(grc_pkg::KIND_SEARCH, 6'd0, 6'd0);
    send_request(grc_pkg::KIND_SEARCH, 6'd63, 6'd63);
    write_include_self(1);
    send_request(grc_pkg::KIND_SEARCH, 6'd63, 6'd0);
    send_request(grc_pkg::KIND_EDGE, 6'd0, 6'd63);
    send_request(grc_pkg::KIND_EDGE, 6'd63, 6'd0);
    send_request(grc_pkg::KIND_EDGE, 6'd0, 6'd21);
    send_request(grc_pkg::KIND_EDGE, 6'd21, 6'd42);
    send_request(grc_pkg::KIND_EDGE, 6'd42, 6'd42);
    send_request(grc_pkg::KIND_SEARCH, 6'd0, 6'd0);
    send_request(grc_pkg::KIND_SEARCH, 6'd42, 6'd0);
    send_request(grc_pkg::KIND_SEARCH, 6'd21, 6'd63);
    write_include_self(0);
    send_request(grc_pkg::KIND_SEARCH, 6'd21, 6'd0);
    send_request(grc_pkg::KIND_SEARCH, 6'd0, 6'd63);
    send_request(grc_pkg::KIND_SEARCH, 6'd5, 6'd0);

    // random graph growth and searches
    for (int i = 0; i < 205; i++) begin
      if (i == 80) write_include_self(1);
      if (i == 160) write_include_self(0);
      idle_pct = (i >= 100 && i < 140) ? 0 : 34;
      if ($urandom_range(99) < 70)
        send_request(grc_pkg::KIND_EDGE, 6'($urandom_range(63)), 6'($urandom_range(63)));
      else
        send_request(grc_pkg::KIND_SEARCH, 6'($urandom_range(63)), 6'($urandom_range(63)));
    end
    for (int i = 0; i < 10; i++)
      send_request(grc_pkg::KIND_SEARCH, 6'($urandom_range(63)), 6'($urandom_range(63)));
    in_valid <= 0;
    sending_done = 1;

    while (sb.pending.size() > 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
